FILE: src/integer_to_radix_digits_top_defines.svh
// assertion helpers for the integer to radix digits block
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ITRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ITRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/itrd_pkg.sv
`default_nettype none

package itrd_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int ADDR_W      = $clog2(VALUE_WIDTH);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

    // controller to datapath
    typedef struct packed {
        logic load;      // take a new input word
        logic div_step;  // one restoring division step
        logic store;     // write remainder digit, start next digit
        logic emit;      // move read digit to the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_step; // final division step of this digit
        logic q_zero;    // quotient left after this digit is zero
        logic cnt_full;  // digit store about to be full
        logic idx_zero;  // reading the least significant digit
        logic out_free;  // output register can take a digit
    } status_t;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_NINE)
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        else
            c = CHAR_ZERO + CHAR_W'(d);
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/itrd_ram.sv
`default_nettype none

module itrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/itrd_ctrl.sv
`default_nettype none

module itrd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire itrd_pkg::status_t status,
    output itrd_pkg::cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.last_step)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (status.q_zero || status.cnt_full)
                    state_next = ST_RD;
                else
                    state_next = ST_DIV;
            end
            ST_RD:
            begin
                // ram read issued at the held index
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.idx_zero)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/itrd_dpath.sv
`default_nettype none

module itrd_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [itrd_pkg::RADIX_W-1:0]  cfg_wdata,
    input  wire logic [itrd_pkg::VALUE_WIDTH-1:0] in_value,
    input  wire logic                          in_is_signed,
    input  wire itrd_pkg::cmd_t                cmd,
    output itrd_pkg::status_t                  status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [itrd_pkg::CHAR_W-1:0]        out_char,
    output logic                               out_negative,
    output logic                               out_last
);

    localparam int VW = itrd_pkg::VALUE_WIDTH;

    logic [itrd_pkg::RADIX_W-1:0] radix_reg;
    logic [itrd_pkg::RADIX_W-1:0] radix_eff;

    logic [VW-1:0]                q_reg;
    logic [itrd_pkg::DIGIT_W-1:0] rem_reg;
    logic [itrd_pkg::STEP_W-1:0]  step_reg;
    logic [itrd_pkg::CNT_W-1:0]   cnt_reg;
    logic [itrd_pkg::ADDR_W-1:0]  idx_reg;
    logic                         neg_reg;

    logic                         out_valid_reg;
    logic [itrd_pkg::CHAR_W-1:0]  out_char_reg;
    logic                         out_neg_reg;
    logic                         out_last_reg;

    logic [VW-1:0]                mag;
    logic                         in_neg;
    logic [itrd_pkg::DIGIT_W:0]   trial;
    logic [itrd_pkg::DIGIT_W:0]   diff;
    logic                         fits;
    logic [itrd_pkg::DIGIT_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= itrd_pkg::RADIX_RESET;
        else if (cfg_wen)
            radix_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (radix_reg < itrd_pkg::RADIX_MIN)
            radix_eff = itrd_pkg::RADIX_MIN;
        else if (radix_reg > itrd_pkg::RADIX_MAX)
            radix_eff = itrd_pkg::RADIX_MAX;
        else
            radix_eff = radix_reg;
    end

    // two's complement magnitude; most negative value stays as 2^(VW-1)
    assign in_neg = in_is_signed & in_value[VW-1];
    assign mag    = in_neg ? (~in_value + VW'(1)) : in_value;

    // restoring division, one quotient bit per step
    assign trial = {rem_reg, q_reg[VW-1]};
    assign diff  = trial - {1'b0, radix_eff};
    assign fits  = (trial >= {1'b0, radix_eff});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg   <= mag;
            rem_reg <= '0;
            neg_reg <= in_neg;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[VW-2:0], fits};
            rem_reg <= fits ? diff[itrd_pkg::DIGIT_W-1:0] : trial[itrd_pkg::DIGIT_W-1:0];
        end
        else if (cmd.store)
        begin
            rem_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (cmd.load || cmd.store)
                step_reg <= '0;
            else if (cmd.div_step)
                step_reg <= step_reg + itrd_pkg::STEP_W'(1);

            if (cmd.load)
                cnt_reg <= '0;
            else if (cmd.store)
                cnt_reg <= cnt_reg + itrd_pkg::CNT_W'(1);

            if (cmd.store)
                idx_reg <= cnt_reg[itrd_pkg::ADDR_W-1:0];
            else if (cmd.emit)
                idx_reg <= idx_reg - itrd_pkg::ADDR_W'(1);
        end
    end

    itrd_ram #(
        .WIDTH (itrd_pkg::DIGIT_W),
        .DEPTH (VW)
    ) u_digits (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (cnt_reg[itrd_pkg::ADDR_W-1:0]),
        .wdata (rem_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= itrd_pkg::to_ascii(ram_rdata);
            out_neg_reg  <= neg_reg;
            out_last_reg <= (idx_reg == '0);
        end
    end

    assign status.last_step = (step_reg == itrd_pkg::STEP_W'(VW - 1));
    assign status.q_zero    = (q_reg == '0);
    assign status.cnt_full  = (cnt_reg == itrd_pkg::CNT_W'(VW - 1));
    assign status.idx_zero  = (idx_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign out_negative = out_neg_reg;
    assign out_last     = out_last_reg;

endmodule

`default_nettype wire

FILE: src/integer_to_radix_digits_top.sv
// channel   dir  tdata (low bit up)             tuser        tlast
// s_*       in   [63:0] value                   is_signed    -
// m_*       out  [6:0] digit_char, [7] zero     negative     last digit of run
// cfg_*     in   cfg_wdata[5:0] radix, written when cfg_wen is high
//
// conversion is set by the one-bit-per-cycle restoring divider (VALUE_WIDTH steps
// per digit) and by the digit ram read per emitted digit
// one word at a time: s_tready is high only while the block is idle
// reset is asynchronous active low; radix returns to 10, no memory clearing
// a stalled m_tready holds the output register and pauses the digit readout
`default_nettype none

module integer_to_radix_digits_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wen,
    input  wire logic [5:0]  cfg_wdata,   // radix
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,     // value
    input  wire logic        s_tuser,     // is_signed
    // digit words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // digit_char, zero pad
    output logic             m_tuser,     // negative
    output logic             m_tlast      // last
);

    itrd_pkg::cmd_t    cmd;
    itrd_pkg::status_t status;
    logic [itrd_pkg::CHAR_W-1:0] digit_char;

    itrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // only the low VALUE_WIDTH bits of the value take part
    itrd_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .in_value     (s_tdata[itrd_pkg::VALUE_WIDTH-1:0]),
        .in_is_signed (s_tuser),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_char     (digit_char),
        .out_negative (m_tuser),
        .out_last     (m_tlast)
    );

    assign m_tdata = {1'b0, digit_char};

endmodule

`default_nettype wire

FILE: src/itrd_checker.sv
`default_nettype none
`include "integer_to_radix_digits_top_defines.svh"

module itrd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    // a new word is never taken in the middle of a run
    `ITRD_ASSERT_NOW(a_no_accept_mid_run, m_tvalid && !m_tlast, !s_tready, "input ready mid run")

    // after accepting a word the block is busy converting
    `ITRD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")

    // digits are always lower-case alphanumerics
    `ITRD_ASSERT_NOW(a_digit_range, m_tvalid, (m_tdata >= 8'h30 && m_tdata <= 8'h39) || (m_tdata >= 8'h61 && m_tdata <= 8'h7a), "bad digit char")

    // stalled output holds
    `ITRD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output dropped while stalled")

endmodule

bind integer_to_radix_digits_top itrd_checker u_itrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

// checks integer_to_radix_digits_top: every accepted value is turned into its
// expected digit words here, and every digit word leaving the block is compared
// against the oldest one still pending, field by field
module testbench;

    import itrd_pkg::*;

    // the watchdog limit is several times the worst case over the whole stimulus,
    // stalls included
    localparam int unsigned CYCLE_LIMIT = 6_000_000;

    // one expected digit word
    typedef struct {
        logic [CHAR_W-1:0] digit_char;
        logic              negative;
        logic              last;
    } digit_word_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // scoreboard state
    digit_word_t          pending_digits[$];
    logic [RADIX_W-1:0]   radix_reg = RADIX_RESET;   // mirror of the block's register
    bit                   radix_written[64];
    bit                   send_gaps_on = 1'b0;
    bit                   stall_on     = 1'b0;
    int unsigned          stall_left   = 0;
    int unsigned          cycle_count  = 0;
    int unsigned          values_sent  = 0;
    int unsigned          digits_seen  = 0;
    int unsigned          negative_runs = 0;
    int unsigned          mismatch_count = 0;

    integer_to_radix_digits_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [63:0] value
        .s_tuser   (s_tuser),     // [0] is_signed
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [6:0] digit_char, [7] zero pad
        .m_tuser   (m_tuser),     // [0] negative
        .m_tlast   (m_tlast)      // last digit of the run
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // register values out of range are clamped to the nearest legal base
    function automatic logic [63:0] effective_base();
        if (radix_reg < RADIX_MIN)
            return 64'(RADIX_MIN);
        else if (radix_reg > RADIX_MAX)
            return 64'(RADIX_MAX);
        else
            return 64'(radix_reg);
    endfunction

    // convert one value and queue its digit words, most significant first
    function automatic void predict_digits(input logic [63:0] value, input logic is_signed);
        logic [63:0]  magnitude;
        logic [63:0]  base;
        logic [5:0]   digit_val[64];
        logic         neg;
        int           n;
        digit_word_t  w;
        base = effective_base();
        neg = is_signed & value[63];
        // two's complement negate; the most negative value stays 2^63 unsigned
        magnitude = neg ? (~value + 64'd1) : value;
        n = 0;
        do begin
            digit_val[n] = 6'(magnitude % base);
            magnitude = magnitude / base;
            n++;
        end while (magnitude != 0 && n < 64);
        for (int k = n - 1; k >= 0; k--)
        begin
            if (digit_val[k] > DIGIT_NINE)
                w.digit_char = CHAR_A + CHAR_W'(digit_val[k] - DIGIT_TEN);
            else
                w.digit_char = CHAR_ZERO + CHAR_W'(digit_val[k]);
            w.negative = neg;
            w.last = (k == 0);
            pending_digits.insert(pending_digits.size(), w);
        end
        if (neg)
            negative_runs++;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // hand one value to the block; returns at the edge where it was taken
    task automatic send_value(input logic [63:0] value, input logic is_signed);
        int unsigned gap;
        gap = send_gaps_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= is_signed;
        do
            @(posedge clk);
        while (!s_tready);
        predict_digits(value, is_signed);
        values_sent++;
    endtask

    // stop sending and wait until every expected digit word came out
    task automatic drain_digits();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_digits.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_radix(input logic [5:0] radix);
        drain_digits();
        // margin for the output register to empty after the last digit
        repeat (4) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= radix;
        @(posedge clk);
        cfg_wen <= 1'b0;
        radix_reg = radix;
        radix_written[radix] = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stalls on m_tready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            // roughly one ready cycle in four draws a stall length, possibly zero, when stalls are enabled
            if (stall_on && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // digit word checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        digit_word_t exp_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            digits_seen++;
            if (pending_digits.size() == 0)
                report_mismatch($sformatf("unexpected digit word tdata=%h tuser=%b tlast=%b",
                                          m_tdata, m_tuser, m_tlast));
            else
            begin
                exp_word = pending_digits.pop_front();
                if (m_tdata[6:0] !== exp_word.digit_char)
                    report_mismatch($sformatf("digit_char %h, expected %h (radix reg %0d)",
                                              m_tdata[6:0], exp_word.digit_char, radix_reg));
                if (m_tdata[7] !== 1'b0)
                    report_mismatch($sformatf("tdata pad bit is %b", m_tdata[7]));
                if (m_tuser !== exp_word.negative)
                    report_mismatch($sformatf("negative %b, expected %b",
                                              m_tuser, exp_word.negative));
                if (m_tlast !== exp_word.last)
                    report_mismatch($sformatf("last %b, expected %b", m_tlast, exp_word.last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // radix 10 straight out of reset: zero, sign handling, full-width values
    task automatic test_reset_radix();
        send_gaps_on = 1'b1;
        stall_on     = 1'b1;
        send_value(64'd0, 1'b0);
        send_value(64'd0, 1'b1);
        send_value(64'd9, 1'b0);
        send_value(64'd10, 1'b1);
        send_value('1, 1'b0);                        // 18446744073709551615
        send_value('1, 1'b1);                        // -1
        send_value(64'h8000_0000_0000_0000, 1'b1);   // most negative, magnitude 2^63
        send_value(64'h8000_0000_0000_0000, 1'b0);
        send_value(64'h7fff_ffff_ffff_ffff, 1'b1);   // largest positive
        send_value(64'd12345, 1'b1);
        drain_digits();
    endtask

    // both ends of the radix range, plus out-of-range register values
    task automatic test_radix_extremes();
        write_radix(6'd2);
        send_value('1, 1'b0);                        // 64 ones, longest run
        send_value(64'h8000_0000_0000_0000, 1'b1);   // 64 digits, all negative
        send_value(64'd1, 1'b0);
        send_value(64'd0, 1'b1);
        write_radix(6'd36);
        send_value(64'd35, 1'b0);                    // single 'z'
        send_value(64'd36, 1'b0);
        send_value('1, 1'b0);
        send_value(-64'sd35, 1'b1);
        // below two behaves as binary
        write_radix(6'd0);
        send_value(64'd5, 1'b0);
        write_radix(6'd1);
        send_value(64'd6, 1'b1);
        // above thirty-six behaves as base 36
        write_radix(6'd37);
        send_value(64'd35, 1'b0);
        write_radix(6'd63);
        send_value(64'd71, 1'b0);
        write_radix(6'd16);
        send_value(64'hfedc_ba98_7654_3210, 1'b0);
        send_value(64'hfedc_ba98_7654_3210, 1'b1);
        drain_digits();
    endtask

    // random values over a series of radix settings and idle patterns
    task automatic test_random_values();
        logic [63:0] value;
        logic [63:0] base;
        logic [63:0] power;
        logic        sgn;
        int unsigned kind;
        int unsigned sel;
        int unsigned exponent;
        for (int phase = 0; phase < 10; phase++)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       write_radix(6'($urandom_range(0, 1)));
                1:       write_radix(6'($urandom_range(37, 63)));
                2:       write_radix(6'd2);
                3:       write_radix(6'd36);
                default: write_radix(6'($urandom_range(3, 35)));
            endcase
            // first phase runs without any idling on either side
            send_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            stall_on     = (phase != 0) && ($urandom_range(0, 3) != 0);
            base = effective_base();
            for (int i = 0; i < 19; i++)
            begin
                kind = $urandom_range(0, 9);
                sgn  = $urandom_range(0, 1);
                case (kind)
                    0, 1, 2, 3: value = {$urandom, $urandom};
                    4, 5:       value = 64'($urandom_range(0, 1000));
                    6:
                    begin
                        value = -64'($urandom_range(1, 1000));
                        sgn = 1'b1;
                    end
                    7:          value = 64'h8000_0000_0000_0000 ^ 64'($urandom_range(0, 3));
                    8:
                    begin
                        // near a power of the base, where the digit count changes
                        power = 64'd1;
                        exponent = $urandom_range(1, 40);
                        repeat (exponent)
                            if (power <= '1 / base)
                                power = power * base;
                        value = power - 64'($urandom_range(0, 1));
                    end
                    default:    value = '1 - 64'($urandom_range(0, 7));
                endcase
                send_value(value, sgn);
            end
            drain_digits();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned radix_settings;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_radix();
        test_radix_extremes();
        test_random_values();

        // let any stray trailing words show up
        drain_digits();
        stall_on = 1'b0;
        repeat (200) @(posedge clk);

        radix_settings = 0;
        foreach (radix_written[r])
            if (radix_written[r])
                radix_settings++;
        $display("covered %0d values (%0d negative) and %0d digit words",
                 values_sent, negative_runs, digits_seen);
        $display("over %0d distinct radix register values, %0d mismatches",
                 radix_settings, mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
